// ===== hw/rtl/tlre_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlre_pkg
// Shared types, codes and lever notch tables for the train lever report
// encoder.
// ----------------------------------------------------------------------------
package tlre_pkg;

	localparam int REPORT_LEN = 6;

	typedef enum logic {
		CMD_SET    = 1'b0,
		CMD_REPORT = 1'b1
	} cmd_t;

	typedef enum logic [3:0] {
		CTL_POWER  = 4'd0,
		CTL_BRAKE  = 4'd1,
		CTL_UP     = 4'd2,
		CTL_RIGHT  = 4'd3,
		CTL_DOWN   = 4'd4,
		CTL_LEFT   = 4'd5,
		CTL_B      = 4'd6,
		CTL_A      = 4'd7,
		CTL_C      = 4'd8,
		CTL_D      = 4'd9,
		CTL_SELECT = 4'd10,
		CTL_START  = 4'd11
	} ctl_id_t;

	typedef enum logic {
		LAYOUT_A = 1'b0,
		LAYOUT_B = 1'b1
	} layout_t;

	// hat: bit 0 up, 1 right, 2 down, 3 left
	// buttons: bit 0 B, 1 A, 2 C, 3 D, 4 select, 5 start
	typedef struct packed {
		logic [7:0] power;
		logic [7:0] brake;
		logic [3:0] hat;
		logic [5:0] buttons;
	} ctl_state_t;

	typedef logic [REPORT_LEN-1:0][7:0] report_t;

	localparam logic [7:0] HAT_RELEASED = 8'h08;
	localparam logic [7:0] BYTE_FILL    = 8'hFF;
	localparam logic [7:0] BYTE_HDR_A   = 8'h01;
	localparam logic [7:0] BYTE_ZERO    = 8'h00;

	// Notch tables: first descending threshold met selects the code.
	function automatic logic [7:0] power_notch_a(input logic [7:0] v);
		logic [7:0] c;
		if (v >= 8'hF8)      c = 8'h00;
		else if (v >= 8'hC8) c = 8'h21;
		else if (v >= 8'h98) c = 8'h3F;
		else if (v >= 8'h58) c = 8'h54;
		else if (v >= 8'h28) c = 8'h6D;
		else                 c = 8'h81;
		return c;
	endfunction

	function automatic logic [7:0] brake_notch_a(input logic [7:0] v);
		logic [7:0] c;
		if (v >= 8'hF8)      c = 8'hB9;
		else if (v >= 8'hE6) c = 8'hB5;
		else if (v >= 8'hCA) c = 8'hB2;
		else if (v >= 8'hAE) c = 8'hAF;
		else if (v >= 8'h92) c = 8'hA8;
		else if (v >= 8'h76) c = 8'hA2;
		else if (v >= 8'h5A) c = 8'h9A;
		else if (v >= 8'h3E) c = 8'h94;
		else if (v >= 8'h22) c = 8'h8A;
		else                 c = 8'h79;
		return c;
	endfunction

	function automatic logic [7:0] power_notch_b(input logic [7:0] v);
		logic [7:0] c;
		if (v >= 8'hF7)      c = 8'hFB;
		else if (v >= 8'hE4) c = 8'hE9;
		else if (v >= 8'hD1) c = 8'hD7;
		else if (v >= 8'hBE) c = 8'hC6;
		else if (v >= 8'hAB) c = 8'hB4;
		else if (v >= 8'h98) c = 8'hA2;
		else if (v >= 8'h85) c = 8'h90;
		else if (v >= 8'h72) c = 8'h7E;
		else if (v >= 8'h5F) c = 8'h6C;
		else if (v >= 8'h4C) c = 8'h5A;
		else if (v >= 8'h39) c = 8'h48;
		else if (v >= 8'h26) c = 8'h36;
		else if (v >= 8'h13) c = 8'h24;
		else                 c = 8'h12;
		return c;
	endfunction

	function automatic logic [7:0] brake_notch_b(input logic [7:0] v);
		logic [7:0] c;
		if (v >= 8'hF8)      c = 8'hFB;
		else if (v >= 8'hCA) c = 8'hDF;
		else if (v >= 8'hAE) c = 8'hC3;
		else if (v >= 8'h92) c = 8'hA7;
		else if (v >= 8'h76) c = 8'h8B;
		else if (v >= 8'h5A) c = 8'h70;
		else if (v >= 8'h3E) c = 8'h54;
		else if (v >= 8'h22) c = 8'h38;
		else                 c = 8'h1C;
		return c;
	endfunction

	// Diagonals win over single directions.
	function automatic logic [7:0] hat_code(input logic [3:0] h);
		logic [7:0] c;
		if (h[0] && h[1])      c = 8'd1;
		else if (h[1] && h[2]) c = 8'd3;
		else if (h[2] && h[3]) c = 8'd5;
		else if (h[3] && h[0]) c = 8'd7;
		else if (h[0])         c = 8'd0;
		else if (h[1])         c = 8'd2;
		else if (h[2])         c = 8'd4;
		else if (h[3])         c = 8'd6;
		else                   c = HAT_RELEASED;
		return c;
	endfunction

	// Layout B order: D, C, B, A, select, start
	function automatic logic [7:0] buttons_b(input logic [5:0] b);
		return {2'b00, b[5], b[4], b[1], b[0], b[2], b[3]};
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tlre_state.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlre_state
// Control state registers: lever levels, hat flags and button bits, updated
// by one set beat per cycle.
// ----------------------------------------------------------------------------
module tlre_state (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 upd_en,
	input  wire logic [3:0]           upd_id,
	input  wire logic [7:0]           upd_value,
	output tlre_pkg::ctl_state_t      state
);
	import tlre_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_nxt;
	logic       hat_on;
	logic       btn_on;

	assign hat_on = (upd_value != 8'h00);
	assign btn_on = upd_value[7];

	always_comb begin
		state_nxt = state_q;
		if (upd_en) begin
			case (upd_id)
				CTL_POWER:  state_nxt.power      = upd_value;
				CTL_BRAKE:  state_nxt.brake      = upd_value;
				CTL_UP:     state_nxt.hat[0]     = hat_on;
				CTL_RIGHT:  state_nxt.hat[1]     = hat_on;
				CTL_DOWN:   state_nxt.hat[2]     = hat_on;
				CTL_LEFT:   state_nxt.hat[3]     = hat_on;
				CTL_B:      state_nxt.buttons[0] = btn_on;
				CTL_A:      state_nxt.buttons[1] = btn_on;
				CTL_C:      state_nxt.buttons[2] = btn_on;
				CTL_D:      state_nxt.buttons[3] = btn_on;
				CTL_SELECT: state_nxt.buttons[4] = btn_on;
				CTL_START:  state_nxt.buttons[5] = btn_on;
				default:    state_nxt = state_q;  // unused ids are dropped
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign state = state_q;

`ifndef NO_ASSERTIONS
	a_unused_id_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_en && upd_id > CTL_START) |=> $stable(state_q))
		else $error("set with unused id changed state");
	a_idle_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		!upd_en |=> $stable(state_q))
		else $error("state changed without a set beat");
	a_power_written: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_en && upd_id == CTL_POWER) |=> state_q.power == $past(upd_value))
		else $error("power level not written");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/tlre_format.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlre_format
// Builds the six report bytes for the selected layout from the control state.
// ----------------------------------------------------------------------------
module tlre_format (
	input  wire logic                 layout,
	input  wire tlre_pkg::ctl_state_t state,
	output tlre_pkg::report_t         report
);
	import tlre_pkg::*;

	logic [7:0] hat;

	assign hat = hat_code(state.hat);

	always_comb begin
		case (layout)
			LAYOUT_A: begin
				report[0] = BYTE_HDR_A;
				report[1] = brake_notch_a(state.brake);
				report[2] = power_notch_a(state.power);
				report[3] = BYTE_FILL;
				report[4] = hat;
				report[5] = {2'b00, state.buttons};
			end
			LAYOUT_B: begin
				report[0] = brake_notch_b(state.brake);
				report[1] = power_notch_b(state.power);
				report[2] = BYTE_FILL;
				report[3] = hat;
				report[4] = buttons_b(state.buttons);
				report[5] = BYTE_ZERO;
			end
			default: report = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tlre_serializer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlre_serializer
// Six-byte shift buffer that sends a loaded report one beat per cycle while
// out_ready is high, and can reload on the cycle its last beat is taken.
// ----------------------------------------------------------------------------
module tlre_serializer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire tlre_pkg::report_t report,
	output logic                   load_ok,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             report_byte,
	output logic                   last
);
	import tlre_pkg::*;

	localparam logic [2:0] LEN = 3'(REPORT_LEN);

	report_t    buf_q;
	logic [2:0] cnt_q;
	logic       beat;

	assign out_valid   = (cnt_q != 3'd0);
	assign beat        = out_valid && out_ready;
	assign last        = (cnt_q == 3'd1);
	assign report_byte = buf_q[0];
	assign load_ok     = !out_valid || (last && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= LEN;
		end else if (beat) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= report;
		end else if (beat) begin
			for (int i = 0; i < REPORT_LEN - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> load_ok)
		else $error("report loaded over one in flight");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LEN)
		else $error("beat count out of range");
	a_last_then_next: assert property (@(posedge clk) disable iff (!arst_n)
		(last && out_ready) |=> (cnt_q == 3'd0 || cnt_q == LEN))
		else $error("bad count after last beat");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/train_lever_report_encoder.sv =====
`default_nettype none
// Report path: an accepted item is registered in the input stage, then the
//   report snapshot is loaded into the byte buffer that presents its bytes.
// Throughput: set items one per cycle unless a report waits in the input
//   stage; six byte beats per report, back to back, paced by the shift buffer.
// Reset: arst_n clears levels, flags, buttons, layout select and all valids.
// ----------------------------------------------------------------------------
// train_lever_report_encoder
// Train lever controller report generator: applies set items to the control
// state and emits six-byte reports in one of two layouts.
// ----------------------------------------------------------------------------
module train_lever_report_encoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       cmd,
	input  wire logic [3:0] control_id,
	input  wire logic [7:0] control_value,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      report_byte,
	output logic            last
);
	import tlre_pkg::*;

	logic       layout_q;
	logic       valid_s1;
	logic       cmd_s1;
	logic [3:0] id_s1;
	logic [7:0] value_s1;
	logic       adv_s1;
	logic       set_en;
	logic       rpt_load;
	logic       load_ok;
	ctl_state_t state;
	report_t    report;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= LAYOUT_A;
		end else if (cfg_valid && cfg_ready) begin
			layout_q <= cfg_data;
		end
	end

	// A set beat always moves on; a report waits for the byte buffer.
	assign adv_s1   = valid_s1 && ((cmd_s1 == CMD_SET) || load_ok);
	assign set_en   = adv_s1 && (cmd_s1 == CMD_SET);
	assign rpt_load = adv_s1 && (cmd_s1 == CMD_REPORT);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1   <= cmd;
			id_s1    <= control_id;
			value_s1 <= control_value;
		end
	end

	tlre_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd_en    (set_en),
		.upd_id    (id_s1),
		.upd_value (value_s1),
		.state     (state)
	);

	tlre_format u_format (
		.layout (layout_q),
		.state  (state),
		.report (report)
	);

	tlre_serializer u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (rpt_load),
		.report      (report),
		.load_ok     (load_ok),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.report_byte (report_byte),
		.last        (last)
	);

`ifndef NO_ASSERTIONS
	a_set_never_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && cmd_s1 == CMD_SET) |-> in_ready)
		else $error("set beat stalled");
	a_report_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !in_ready) |-> (cmd_s1 == CMD_REPORT && out_valid))
		else $error("input stalled with free byte buffer");
	a_report_starts_out: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_load |=> (out_valid && !last))
		else $error("loaded report not presented");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the train lever report encoder. A behavioral
// tracker keeps its own copy of the lever levels, hat flags, buttons and
// layout, predicts every report beat, and a checker compares each output
// beat with the oldest prediction. Directed extremes, a layout B check and
// a long output stall come first, then random traffic in both layouts with
// random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tlre_pkg::*;

	localparam int          STALL_LIMIT   = 2000;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          HOLD_CYCLES   = 80;
	localparam logic [3:0]  CTL_FREE_LO   = 4'd12;
	localparam logic [3:0]  CTL_FREE_HI   = 4'd15;
	localparam logic [7:0]  BTN_ON_MIN    = 8'd128;

	// notch tables, padded to 14 entries: thresholds descend, code per notch
	localparam logic [0:13][7:0] PWR_A_TH = {8'hF8, 8'hC8, 8'h98, 8'h58, 8'h28, 8'h00,
		{8{8'h00}}};
	localparam logic [0:13][7:0] PWR_A_CD = {8'h00, 8'h21, 8'h3F, 8'h54, 8'h6D, 8'h81,
		{8{8'h00}}};
	localparam logic [0:13][7:0] BRK_A_TH = {8'hF8, 8'hE6, 8'hCA, 8'hAE, 8'h92, 8'h76,
		8'h5A, 8'h3E, 8'h22, 8'h00, {4{8'h00}}};
	localparam logic [0:13][7:0] BRK_A_CD = {8'hB9, 8'hB5, 8'hB2, 8'hAF, 8'hA8, 8'hA2,
		8'h9A, 8'h94, 8'h8A, 8'h79, {4{8'h00}}};
	localparam logic [0:13][7:0] PWR_B_TH = {8'hF7, 8'hE4, 8'hD1, 8'hBE, 8'hAB, 8'h98,
		8'h85, 8'h72, 8'h5F, 8'h4C, 8'h39, 8'h26, 8'h13, 8'h00};
	localparam logic [0:13][7:0] PWR_B_CD = {8'hFB, 8'hE9, 8'hD7, 8'hC6, 8'hB4, 8'hA2,
		8'h90, 8'h7E, 8'h6C, 8'h5A, 8'h48, 8'h36, 8'h24, 8'h12};
	localparam logic [0:13][7:0] BRK_B_TH = {8'hF8, 8'hCA, 8'hAE, 8'h92, 8'h76, 8'h5A,
		8'h3E, 8'h22, 8'h00, {5{8'h00}}};
	localparam logic [0:13][7:0] BRK_B_CD = {8'hFB, 8'hDF, 8'hC3, 8'hA7, 8'h8B, 8'h70,
		8'h54, 8'h38, 8'h1C, {5{8'h00}}};

	typedef struct packed {
		logic [7:0] data;
		logic       eop;
	} report_beat_t;

	logic       clk;
	logic       arst_n        = 1'b0;
	logic       cfg_valid     = 1'b0;
	logic       cfg_ready;
	logic       cfg_data      = 1'b0;
	logic       in_valid      = 1'b0;
	logic       in_ready;
	logic       cmd           = 1'b0;
	logic [3:0] control_id    = 4'd0;
	logic [7:0] control_value = 8'd0;
	logic       out_valid;
	logic       out_ready     = 1'b0;
	logic [7:0] report_byte;
	logic       last;

	// tracked controller state
	layout_t    cur_layout = LAYOUT_A;
	logic [7:0] lv_power   = 8'd0;
	logic [7:0] lv_brake   = 8'd0;
	logic [3:0] hat_mask   = 4'd0;
	logic [5:0] btn_mask   = 6'd0;

	report_beat_t pending_bytes[$];
	report_beat_t want;
	int           errors      = 0;
	int           idle_cycles = 0;
	int           rx_wait     = 0;
	int           hold_req    = 0;
	bit           tx_gaps_on  = 1'b1;
	bit           rx_gaps_on  = 1'b1;

	train_lever_report_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.control_id   (control_id),
		.control_value(control_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.report_byte  (report_byte),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [7:0] notch_code(input logic [7:0] v,
			input logic [0:13][7:0] th, input logic [0:13][7:0] cd, input int n);
		for (int i = 0; i < n; i++)
			if (v >= th[i])
				return cd[i];
		return cd[n-1];
	endfunction

	function automatic logic [7:0] hat_direction(input logic [3:0] m);
		logic up, rt, dn, lf;
		up = m[0];
		rt = m[1];
		dn = m[2];
		lf = m[3];
		if (up && rt) return 8'd1;
		if (rt && dn) return 8'd3;
		if (dn && lf) return 8'd5;
		if (lf && up) return 8'd7;
		if (up) return 8'd0;
		if (rt) return 8'd2;
		if (dn) return 8'd4;
		if (lf) return 8'd6;
		return HAT_RELEASED;
	endfunction

	function automatic logic [7:0] layout_b_buttons(input logic [5:0] b);
		logic [7:0] r;
		r      = 8'd0;
		r[0]   = b[3];
		r[1]   = b[2];
		r[2]   = b[0];
		r[3]   = b[1];
		r[5:4] = b[5:4];
		return r;
	endfunction

	task automatic push_report();
		logic [7:0] rpt [REPORT_LEN];
		report_beat_t beat;
		if (cur_layout == LAYOUT_A) begin
			rpt[0] = BYTE_HDR_A;
			rpt[1] = notch_code(lv_brake, BRK_A_TH, BRK_A_CD, 10);
			rpt[2] = notch_code(lv_power, PWR_A_TH, PWR_A_CD, 6);
			rpt[3] = BYTE_FILL;
			rpt[4] = hat_direction(hat_mask);
			rpt[5] = {2'b00, btn_mask};
		end else begin
			rpt[0] = notch_code(lv_brake, BRK_B_TH, BRK_B_CD, 9);
			rpt[1] = notch_code(lv_power, PWR_B_TH, PWR_B_CD, 14);
			rpt[2] = BYTE_FILL;
			rpt[3] = hat_direction(hat_mask);
			rpt[4] = layout_b_buttons(btn_mask);
			rpt[5] = BYTE_ZERO;
		end
		for (int k = 0; k < REPORT_LEN; k++) begin
			beat.data = rpt[k];
			beat.eop  = (k == REPORT_LEN - 1);
			pending_bytes.push_back(beat);
		end
	endtask

	task automatic track_item(input cmd_t op, input logic [3:0] id, input logic [7:0] val);
		if (op == CMD_REPORT)
			push_report();
		else if (id == CTL_POWER)
			lv_power = val;
		else if (id == CTL_BRAKE)
			lv_brake = val;
		else if (id >= CTL_UP && id <= CTL_LEFT)
			hat_mask[id - CTL_UP] = (val != 8'd0);
		else if (id >= CTL_B && id <= CTL_START)
			btn_mask[id - CTL_B] = (val >= BTN_ON_MIN);
		// ids above start are ignored
	endtask

	// valid stays up between back-to-back beats; dropped only for a gap
	task automatic send_item(input cmd_t op, input logic [3:0] id, input logic [7:0] val);
		int gap;
		gap = tx_gaps_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= op;
		control_id    <= id;
		control_value <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		track_item(op, id, val);
	endtask

	// set items leave no trace in the output, so give the pipe time to settle
	task automatic drain_reports();
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_layout(input layout_t lay);
		cfg_valid <= 1'b1;
		cfg_data  <= lay;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_layout = lay;
	endtask

	function automatic logic [7:0] axis_value();
		logic [7:0] t;
		int d;
		if ($urandom_range(0, 1))
			return 8'($urandom_range(0, 255));
		case ($urandom_range(0, 3))
			0:       t = PWR_A_TH[$urandom_range(0, 5)];
			1:       t = BRK_A_TH[$urandom_range(0, 9)];
			2:       t = PWR_B_TH[$urandom_range(0, 13)];
			default: t = BRK_B_TH[$urandom_range(0, 8)];
		endcase
		d = $urandom_range(0, 2);
		return 8'(int'(t) + d - 1); // straddle the notch edge
	endfunction

	task automatic test_reset_report();
		send_item(CMD_REPORT, CTL_POWER, 8'd0);
	endtask

	task automatic test_control_extremes();
		send_item(CMD_SET, CTL_POWER, 8'd255);
		send_item(CMD_SET, CTL_BRAKE, 8'd255);
		send_item(CMD_SET, CTL_UP, 8'd1);
		send_item(CMD_SET, CTL_RIGHT, 8'd255);
		send_item(CMD_SET, CTL_B, 8'd128);
		send_item(CMD_SET, CTL_A, 8'd255);
		send_item(CMD_SET, CTL_C, 8'd127);
		send_item(CMD_SET, CTL_D, 8'd200);
		send_item(CMD_SET, CTL_SELECT, 8'd128);
		send_item(CMD_SET, CTL_START, 8'd255);
		send_item(CMD_SET, CTL_FREE_LO, 8'd255);
		send_item(CMD_SET, CTL_FREE_HI, 8'hAA);
		send_item(CMD_REPORT, CTL_FREE_HI, 8'd255);
	endtask

	task automatic test_layout_b();
		drain_reports();
		write_layout(LAYOUT_B);
		send_item(CMD_REPORT, CTL_POWER, 8'd0);
		// all four flags set, then only down and left
		send_item(CMD_SET, CTL_DOWN, 8'h80);
		send_item(CMD_SET, CTL_LEFT, 8'd1);
		send_item(CMD_SET, CTL_UP, 8'd0);
		send_item(CMD_SET, CTL_RIGHT, 8'd0);
		send_item(CMD_SET, CTL_POWER, 8'd0);
		send_item(CMD_SET, CTL_BRAKE, 8'h22);
		send_item(CMD_SET, CTL_C, 8'd128);
		send_item(CMD_SET, CTL_START, 8'd0);
		send_item(CMD_REPORT, CTL_START, 8'd0);
	endtask

	task automatic test_output_stall();
		drain_reports();
		tx_gaps_on = 1'b0;
		hold_req   = HOLD_CYCLES;
		for (int i = 0; i < 20; i++) begin
			if (i % 4 == 3)
				send_item(CMD_SET, CTL_POWER, axis_value());
			else
				send_item(CMD_REPORT, CTL_BRAKE, 8'd0);
		end
		tx_gaps_on = 1'b1;
		drain_reports();
	endtask

	task automatic test_random_traffic(input layout_t lay, input int n_items);
		int pick;
		logic [3:0] id;
		logic [7:0] val;
		drain_reports();
		write_layout(lay);
		for (int i = 0; i < n_items; i++) begin
			if (i % 25 == 0) begin
				tx_gaps_on = ($urandom_range(0, 3) != 0);
				rx_gaps_on = ($urandom_range(0, 3) != 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				id  = 4'($urandom_range(0, 15));
				val = 8'($urandom_range(0, 255));
				send_item(CMD_REPORT, id, val);
			end else begin
				if (pick < 35)
					id = 4'($urandom_range(CTL_FREE_LO, CTL_FREE_HI));
				else
					id = 4'($urandom_range(CTL_POWER, CTL_START));
				if (id <= CTL_BRAKE)
					val = axis_value();
				else if (id <= CTL_LEFT)
					val = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
				else if ($urandom_range(0, 3) == 0)
					val = $urandom_range(0, 1) ? BTN_ON_MIN : BTN_ON_MIN - 8'd1;
				else
					val = 8'($urandom_range(0, 255));
				send_item(CMD_SET, id, val);
			end
		end
	endtask

	// receiver: random stall after each beat, plus an occasional long hold
	always @(posedge clk) begin
		if (hold_req > 0) begin
			rx_wait  = hold_req;
			hold_req = 0;
		end else if (out_valid && out_ready)
			rx_wait = rx_gaps_on ? $urandom_range(0, 3) : 0;
		else if (rx_wait > 0)
			rx_wait--;
		out_ready <= (rx_wait == 0);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat: expected none, got byte %02h last %0b",
					$time, report_byte, last);
			end else begin
				want = pending_bytes.pop_front();
				if (report_byte !== want.data) begin
					errors++;
					$display("%0t: report_byte mismatch: expected %02h, got %02h",
						$time, want.data, report_byte);
				end
				if (last !== want.eop) begin
					errors++;
					$display("%0t: last mismatch: expected %0b, got %0b",
						$time, want.eop, last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_report();
		test_control_extremes();
		test_layout_b();
		test_output_stall();
		test_random_traffic(LAYOUT_A, 104);
		test_random_traffic(LAYOUT_B, 104);
		test_random_traffic(LAYOUT_A, 104);
		test_random_traffic(LAYOUT_B, 104);
		drain_reports();
		repeat (10) @(posedge clk);
		if (errors == 0 && pending_bytes.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/tlre_pkg.sv
hw/rtl/tlre_state.sv
hw/rtl/tlre_format.sv
hw/rtl/tlre_serializer.sv
hw/rtl/train_lever_report_encoder.sv
tb/sv/tb_top.sv
